### hw/rtl/fdht_pkg.sv
// ----------------------------------------------------------------------------
// fdht_pkg
// Shared types and constants of the fitness-displacing slot table.
// ----------------------------------------------------------------------------
package fdht_pkg;

    // Table geometry; the slot count is a power of two so the walk wraps.
    localparam int TABLE_SLOTS = 1024;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);

    // Field widths.
    localparam int HASH_W  = 64;
    localparam int FIT_W   = 32;
    localparam int DATA_W  = 64;
    localparam int LIMIT_W = 7;
    localparam int STEP_W  = 4;
    localparam int WORD_W  = DATA_W + FIT_W;

    // Step base. Since 2^12 mod 13 is 1, the hash is folded into a sum of
    // 12-bit chunks, and the small sum is reduced by a reciprocal multiply.
    localparam logic [STEP_W-1:0] STEP_BASE   = 4'd13;
    localparam int                FOLD_SUM_W  = 15;
    localparam int                RED_W       = 13;
    localparam logic [RED_W-1:0]  RECIP_MUL   = 13'd5042;
    localparam int                RECIP_SHIFT = 16;

    // Largest fitness kept; all ones saturates to this.
    localparam logic [FIT_W-1:0] FIT_MAX = 32'hFFFF_FFFE;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_READ   = 2'd1,
        FUNC_CLEAR  = 2'd2,
        FUNC_NOP    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_PLACED    = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_DROPPED   = 2'd2,
        ST_NONE      = 2'd3
    } status_t;

    // Register indexes of the configuration port.
    localparam logic REG_PROBE_LIMIT = 1'b0;
    localparam logic REG_HALT_FIT    = 1'b1;

    // One classified item on its way from the front to the back.
    typedef struct packed {
        func_t             func;
        logic [SLOT_W-1:0] start_pos;
        logic [STEP_W-1:0] step;
        logic [FIT_W-1:0]  fitness;
        logic [DATA_W-1:0] data;
        logic [SLOT_W-1:0] slot_index;
    } entry_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

### hw/rtl/fdht_ram.sv
// ----------------------------------------------------------------------------
// fdht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fdht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hw/rtl/fdht_queue.sv
// ----------------------------------------------------------------------------
// fdht_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module fdht_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  fdht_pkg::entry_t push_entry,
    input  logic            pop,
    output fdht_pkg::entry_t pop_entry,
    output fdht_pkg::q_stat_t stat
);
    import fdht_pkg::*;

    entry_t     slots_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign pop_entry  = slots_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);

endmodule

### hw/rtl/fdht_front.sv
// ----------------------------------------------------------------------------
// fdht_front
// Accepts items, saturates the fitness and works out the start slot and the
// probe step (13 less the hash mod 13, by chunk folding and a reciprocal
// multiply) before queuing.
// ----------------------------------------------------------------------------
module fdht_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [1:0]                func,
    input  logic [fdht_pkg::HASH_W-1:0] item_hash,
    input  logic [fdht_pkg::FIT_W-1:0]  item_fitness,
    input  logic [fdht_pkg::DATA_W-1:0] item_data,
    input  logic [fdht_pkg::SLOT_W-1:0] slot_index,
    input  fdht_pkg::q_stat_t         q_stat,
    output logic                      q_push,
    output fdht_pkg::entry_t          q_entry
);
    import fdht_pkg::*;

    typedef enum logic [1:0] {
        F_IDLE,
        F_FOLD,
        F_REDUCE,
        F_PUSH
    } fstate_t;

    fstate_t               state_reg, state_next;
    entry_t                ent_reg, ent_next;
    logic [HASH_W-1:0]     hash_reg, hash_next;
    logic [FOLD_SUM_W-1:0] sum_reg, sum_next;
    logic [FOLD_SUM_W-1:0] fold_sum;
    logic [RED_W-1:0]      fold_val;
    logic [2*RED_W-1:0]    red_prod;
    logic [9:0]            red_quot;
    logic [RED_W-1:0]      red_rem;

    // The hash is congruent to the sum of its 12-bit chunks; the sum is
    // folded once more and reduced by a reciprocal multiply.
    always_comb begin
        fold_sum = FOLD_SUM_W'(hash_reg[11:0]) + FOLD_SUM_W'(hash_reg[23:12])
                 + FOLD_SUM_W'(hash_reg[35:24]) + FOLD_SUM_W'(hash_reg[47:36])
                 + FOLD_SUM_W'(hash_reg[59:48]) + FOLD_SUM_W'(hash_reg[63:60]);
        fold_val = RED_W'(sum_reg[11:0]) + RED_W'(sum_reg[14:12]);
        red_prod = (2*RED_W)'(fold_val) * (2*RED_W)'(RECIP_MUL);
        red_quot = red_prod[RECIP_SHIFT +: 10];
        red_rem  = fold_val - RED_W'(RED_W'(red_quot) * RED_W'(STEP_BASE));
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        ent_next   = ent_reg;
        hash_next  = hash_reg;
        sum_next   = sum_reg;
        q_push     = 1'b0;
        unique case (state_reg)
            F_IDLE: begin
                if (s_tvalid) begin
                    ent_next.func       = func_t'(func);
                    ent_next.start_pos  = item_hash[SLOT_W-1:0];
                    ent_next.step       = STEP_BASE;
                    ent_next.fitness    = (item_fitness > FIT_MAX) ? FIT_MAX : item_fitness;
                    ent_next.data       = item_data;
                    ent_next.slot_index = slot_index;
                    hash_next           = item_hash;
                    state_next = (func_t'(func) == FUNC_INSERT) ? F_FOLD : F_PUSH;
                end
            end
            F_FOLD: begin
                sum_next   = fold_sum;
                state_next = F_REDUCE;
            end
            F_REDUCE: begin
                ent_next.step = STEP_BASE - red_rem[STEP_W-1:0];
                state_next    = F_PUSH;
            end
            F_PUSH: begin
                if (!q_stat.full) begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        ent_reg  <= ent_next;
        hash_reg <= hash_next;
        sum_reg  <= sum_next;
    end

    assign s_tready = (state_reg == F_IDLE);
    assign q_entry  = ent_reg;

endmodule

### hw/rtl/fdht_back.sv
// ----------------------------------------------------------------------------
// fdht_back
// Executes queued operations against the slot memory: probe walk with
// displacement, slot read, and the clearing sweep. Owns the result register.
// ----------------------------------------------------------------------------
module fdht_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  fdht_pkg::q_stat_t           q_stat,
    input  fdht_pkg::entry_t            q_entry,
    output logic                        q_pop,
    input  logic [fdht_pkg::LIMIT_W-1:0] probe_limit,
    input  logic [fdht_pkg::FIT_W-1:0]  halt_fit,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [1:0]                  insert_status,
    output logic                        early_stop,
    output logic [fdht_pkg::FIT_W-1:0]  read_fitness,
    output logic [fdht_pkg::DATA_W-1:0] read_data
);
    import fdht_pkg::*;

    typedef enum logic [2:0] {
        B_SWEEP,
        B_IDLE,
        B_READ,
        B_PROBE,
        B_RESULT
    } bstate_t;

    bstate_t            state_reg, state_next;
    logic [SLOT_W-1:0]  sweep_reg, sweep_next;
    logic               sweep_pend_reg, sweep_pend_next;
    logic               stop_reg, stop_next;
    logic [SLOT_W-1:0]  pos_reg, pos_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [LIMIT_W-1:0] cnt_reg, cnt_next;
    logic [FIT_W-1:0]   cur_fit_reg, cur_fit_next;
    logic [DATA_W-1:0]  cur_data_reg, cur_data_next;
    status_t            res_status_reg, res_status_next;
    logic [FIT_W-1:0]   res_fit_reg, res_fit_next;
    logic [DATA_W-1:0]  res_data_reg, res_data_next;
    logic               m_valid_reg, m_valid_next;
    status_t            m_status_reg, m_status_next;
    logic               m_stop_reg, m_stop_next;
    logic [FIT_W-1:0]   m_fit_reg, m_fit_next;
    logic [DATA_W-1:0]  m_data_reg, m_data_next;

    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic [WORD_W-1:0] rd_data;
    logic [FIT_W-1:0]  occ_fit;
    logic [DATA_W-1:0] occ_data;
    logic [SLOT_W-1:0] pos_step;

    assign occ_fit  = rd_data[FIT_W-1:0];
    assign occ_data = rd_data[WORD_W-1:FIT_W];
    assign pos_step = pos_reg + SLOT_W'(step_reg);

    // Slot memory: payload in the upper bits, fitness in the lower bits.
    fdht_ram #(
        .WIDTH(WORD_W),
        .DEPTH(TABLE_SLOTS)
    ) u_slots (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // Operation sequencer.
    always_comb begin
        state_next      = state_reg;
        sweep_next      = sweep_reg;
        sweep_pend_next = sweep_pend_reg;
        stop_next       = stop_reg;
        pos_next        = pos_reg;
        step_next       = step_reg;
        cnt_next        = cnt_reg;
        cur_fit_next    = cur_fit_reg;
        cur_data_next   = cur_data_reg;
        res_status_next = res_status_reg;
        res_fit_next    = res_fit_reg;
        res_data_next   = res_data_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_stop_next     = m_stop_reg;
        m_fit_next      = m_fit_reg;
        m_data_next     = m_data_reg;
        q_pop           = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = pos_reg;
        wr_data         = {cur_data_reg, cur_fit_reg};
        rd_en           = 1'b0;
        rd_addr         = pos_reg;
        unique case (state_reg)
            B_SWEEP: begin
                wr_en      = 1'b1;
                wr_addr    = sweep_reg;
                wr_data    = '0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == SLOT_W'(TABLE_SLOTS - 1)) begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE: begin
                if (!q_stat.empty) begin
                    q_pop           = 1'b1;
                    res_status_next = ST_NONE;
                    res_fit_next    = '0;
                    res_data_next   = '0;
                    unique case (q_entry.func)
                        FUNC_INSERT: begin
                            if (q_entry.fitness == halt_fit) begin
                                stop_next = 1'b1;
                            end
                            cur_fit_next  = q_entry.fitness;
                            cur_data_next = q_entry.data;
                            pos_next      = q_entry.start_pos;
                            step_next     = q_entry.step;
                            cnt_next      = '0;
                            if (q_entry.fitness == '0 || probe_limit == '0) begin
                                res_status_next = ST_DROPPED;
                                state_next      = B_RESULT;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = q_entry.start_pos;
                                state_next = B_PROBE;
                            end
                        end
                        FUNC_READ: begin
                            rd_en      = 1'b1;
                            rd_addr    = q_entry.slot_index;
                            state_next = B_READ;
                        end
                        FUNC_CLEAR: begin
                            stop_next       = 1'b0;
                            sweep_next      = '0;
                            sweep_pend_next = 1'b1;
                            state_next      = B_RESULT;
                        end
                        FUNC_NOP: state_next = B_RESULT;
                        default:  state_next = B_RESULT;
                    endcase
                end
            end
            B_READ: begin
                res_fit_next  = occ_fit;
                res_data_next = occ_data;
                state_next    = B_RESULT;
            end
            B_PROBE: begin
                // One probe per cycle: decide on the slot just read and
                // fetch the next one in the same cycle.
                cnt_next = cnt_reg + 1'b1;
                if (occ_fit == '0) begin
                    wr_en           = 1'b1;
                    res_status_next = ST_PLACED;
                    state_next      = B_RESULT;
                end else if (occ_fit == cur_fit_reg && occ_data == cur_data_reg) begin
                    res_status_next = ST_DUPLICATE;
                    state_next      = B_RESULT;
                end else begin
                    if (occ_fit < cur_fit_reg) begin
                        wr_en         = 1'b1;
                        cur_fit_next  = occ_fit;
                        cur_data_next = occ_data;
                    end
                    if (cnt_next == probe_limit) begin
                        res_status_next = ST_DROPPED;
                        state_next      = B_RESULT;
                    end else begin
                        pos_next = pos_step;
                        rd_en    = 1'b1;
                        rd_addr  = pos_step;
                    end
                end
            end
            B_RESULT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next    = 1'b1;
                    m_status_next   = res_status_reg;
                    m_stop_next     = stop_reg;
                    m_fit_next      = res_fit_reg;
                    m_data_next     = res_data_reg;
                    sweep_pend_next = 1'b0;
                    state_next      = sweep_pend_reg ? B_SWEEP : B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= B_SWEEP;
            sweep_reg      <= '0;
            sweep_pend_reg <= 1'b0;
            stop_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            sweep_reg      <= sweep_next;
            sweep_pend_reg <= sweep_pend_next;
            stop_reg       <= stop_next;
            m_valid_reg    <= m_valid_next;
        end
        pos_reg        <= pos_next;
        step_reg       <= step_next;
        cnt_reg        <= cnt_next;
        cur_fit_reg    <= cur_fit_next;
        cur_data_reg   <= cur_data_next;
        res_status_reg <= res_status_next;
        res_fit_reg    <= res_fit_next;
        res_data_reg   <= res_data_next;
        m_status_reg   <= m_status_next;
        m_stop_reg     <= m_stop_next;
        m_fit_reg      <= m_fit_next;
        m_data_reg     <= m_data_next;
    end

    assign m_tvalid      = m_valid_reg;
    assign insert_status = m_status_reg;
    assign early_stop    = m_stop_reg;
    assign read_fitness  = m_fit_reg;
    assign read_data     = m_data_reg;

endmodule

### hw/rtl/fitness_displacing_hash_table_top.sv
// ----------------------------------------------------------------------------
// fitness_displacing_hash_table_top
// Slot table with double hashing and displacement of weaker occupants.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one operation per item: insert, read slot, clear or
//   no operation. Every item gives exactly one result item on the m_ channel.
//   The front accepts an insert, folds the hash, reduces it mod 13 and then
//   pushes it; any other item is accepted and pushed. A two-entry queue lets
//   the back work on earlier items meanwhile.
//   The back makes one probe per cycle through the slot memory's read port.
//   Reset starts a clearing pass over all 1024 slots of the memory; items
//   are accepted and queued meanwhile but execute only after it ends. A clear
//   item gives its result and then runs the same clearing pass.
//   When the receiver stalls, the result stays in its output register, the
//   back holds one finished item, two wait in the queue and one in the front;
//   then the input stalls. Configuration writes must only be made idle.
// ----------------------------------------------------------------------------
module fitness_displacing_hash_table_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [31:0]   cfg_wdata,
    input  logic          s_tvalid,
    output logic          s_tready,
    // func[1:0], item_hash[65:2], item_fitness[97:66], item_data[161:98],
    // slot_index[171:162], zero fill up to 176 bits.
    input  logic [175:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // insert_status[1:0], early_stop[2], read_fitness[34:3],
    // read_data[98:35], zero fill up to 104 bits.
    output logic [103:0]  m_tdata
);
    import fdht_pkg::*;

    logic [LIMIT_W-1:0] probe_limit_reg;
    logic [FIT_W-1:0]   halt_fit_reg;
    q_stat_t            q_stat;
    logic               q_push;
    logic               q_pop;
    entry_t             push_entry;
    entry_t             pop_entry;
    logic [1:0]         insert_status;
    logic               early_stop;
    logic [FIT_W-1:0]   read_fitness;
    logic [DATA_W-1:0]  read_data;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probe_limit_reg <= 7'd8;
            halt_fit_reg    <= FIT_MAX;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_PROBE_LIMIT: probe_limit_reg <= cfg_wdata[LIMIT_W-1:0];
                REG_HALT_FIT:    halt_fit_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    fdht_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .func        (s_tdata[1:0]),
        .item_hash   (s_tdata[65:2]),
        .item_fitness(s_tdata[97:66]),
        .item_data   (s_tdata[161:98]),
        .slot_index  (s_tdata[171:162]),
        .q_stat      (q_stat),
        .q_push      (q_push),
        .q_entry     (push_entry)
    );

    fdht_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_entry(push_entry),
        .pop       (q_pop),
        .pop_entry (pop_entry),
        .stat      (q_stat)
    );

    fdht_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_stat       (q_stat),
        .q_entry      (pop_entry),
        .q_pop        (q_pop),
        .probe_limit  (probe_limit_reg),
        .halt_fit     (halt_fit_reg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .insert_status(insert_status),
        .early_stop   (early_stop),
        .read_fitness (read_fitness),
        .read_data    (read_data)
    );

    assign m_tdata = {5'd0, read_data, read_fitness, early_stop, insert_status};

    // The queue is never pushed when full nor popped when empty.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_stat.full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty)
        else $error("queue pop while empty");

    // Only a read result carries slot contents.
    a_read_only_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && insert_status != ST_NONE) |-> (read_fitness == '0))
        else $error("slot contents on a non-read result");

    // Nothing is presented right after reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule
